// ===== design/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Shared widths, operation codes and the line set-up record for the
// Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned CoordBits = 12;
  // signed error term and increments: width is three bits above a coordinate
  localparam int unsigned ErrBits   = CoordBits + 3;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [ErrBits-1:0] err_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef struct packed {
    logic   steep;
    logic   minor_neg;
    coord_t start_x;
    coord_t start_y;
    err_t   err_init;
    err_t   inc_straight;
    err_t   inc_diagonal;
    coord_t major_len;
  } line_setup_t;

endpackage : bls_pkg

// ===== design/bls_setup.sv =====
// ----------------------------------------------------------------------------
// bls_setup
// Line set-up: picks the major axis, the start endpoint, the minor step
// direction and the initial error term and increments.
// ----------------------------------------------------------------------------
module bls_setup (
  input  bls_pkg::coord_t      x_start_i,
  input  bls_pkg::coord_t      y_start_i,
  input  bls_pkg::coord_t      x_end_i,
  input  bls_pkg::coord_t      y_end_i,
  output bls_pkg::line_setup_t setup_o
);
  import bls_pkg::*;

  coord_t adx;
  coord_t ady;
  coord_t major_len;
  coord_t minor_len;
  logic   steep;
  err_t   minor2;
  err_t   major_ext;

  assign adx = (x_end_i >= x_start_i) ? coord_t'(x_end_i - x_start_i)
                                      : coord_t'(x_start_i - x_end_i);
  assign ady = (y_end_i >= y_start_i) ? coord_t'(y_end_i - y_start_i)
                                      : coord_t'(y_start_i - y_end_i);
  assign steep     = ady > adx;
  assign major_len = steep ? ady : adx;
  assign minor_len = steep ? adx : ady;
  assign minor2    = err_t'({minor_len, 1'b0});
  assign major_ext = err_t'(major_len);

  always_comb begin
    setup_o.steep        = steep;
    setup_o.major_len    = major_len;
    setup_o.inc_straight = minor2;
    setup_o.inc_diagonal = minor2 - (major_ext <<< 1);
    setup_o.err_init     = minor2 - major_ext;
    if (steep) begin
      if (y_start_i <= y_end_i) begin
        setup_o.start_x   = x_start_i;
        setup_o.start_y   = y_start_i;
        setup_o.minor_neg = x_end_i < x_start_i;
      end else begin
        setup_o.start_x   = x_end_i;
        setup_o.start_y   = y_end_i;
        setup_o.minor_neg = x_end_i > x_start_i;
      end
    end else begin
      if (x_start_i <= x_end_i) begin
        setup_o.start_x   = x_start_i;
        setup_o.start_y   = y_start_i;
        setup_o.minor_neg = y_end_i < y_start_i;
      end else begin
        setup_o.start_x   = x_end_i;
        setup_o.start_y   = y_end_i;
        setup_o.minor_neg = y_end_i > y_start_i;
      end
    end
  end

endmodule : bls_setup

// ===== design/bresenham_line_stepper.sv =====
// A step item's pixel passes the input register, then enters the result
// register as the line state updates. Throughput: one item per cycle while
// the result side is not stalled; the error update is one add and a sign test.
// A stall on the result side holds the input register and raises in_stall_o.
// Reset (rst_ni low, asynchronous) leaves no line active and no item held.
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer Bresenham rasteriser: load items set up a line, step items emit
// one pixel each while a line is active, the final pixel marked.
// ----------------------------------------------------------------------------
module bresenham_line_stepper (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  bls_pkg::coord_t x_start_i,
  input  bls_pkg::coord_t y_start_i,
  input  bls_pkg::coord_t x_end_i,
  input  bls_pkg::coord_t y_end_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bls_pkg::coord_t pixel_x_o,
  output bls_pkg::coord_t pixel_y_o,
  output logic            last_pixel_o
);
  import bls_pkg::*;

  // input register
  logic   in_valid_q;
  op_e    op_q;
  coord_t xs_q, ys_q, xe_q, ye_q;

  // line state
  logic   active_q, active_d;
  logic   steep_q, steep_d;
  logic   minor_neg_q, minor_neg_d;
  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  err_t   err_q, err_d;
  err_t   inc_s_q, inc_s_d;
  err_t   inc_d_q, inc_d_d;
  coord_t left_q, left_d;

  // result register
  logic   out_valid_q, out_valid_d;
  coord_t pix_x_q, pix_y_q;
  logic   last_q;

  line_setup_t setup;
  logic        stage_blocked;
  logic        proc_fire;
  logic        step_fire;
  coord_t      minor_next;
  coord_t      minor_cur;

  bls_setup u_setup (
    .x_start_i (xs_q),
    .y_start_i (ys_q),
    .x_end_i   (xe_q),
    .y_end_i   (ye_q),
    .setup_o   (setup)
  );

  assign stage_blocked = out_valid_q & out_stall_i;
  assign in_stall_o    = in_valid_q & stage_blocked;
  assign proc_fire     = in_valid_q & ~stage_blocked;
  assign step_fire     = proc_fire & (op_q == OP_STEP) & active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q <= op_e'(operation_i);
      xs_q <= x_start_i;
      ys_q <= y_start_i;
      xe_q <= x_end_i;
      ye_q <= y_end_i;
    end
  end

  assign minor_cur  = steep_q ? cur_x_q : cur_y_q;
  assign minor_next = minor_neg_q ? coord_t'(minor_cur - 1'b1)
                                  : coord_t'(minor_cur + 1'b1);

  always_comb begin
    active_d    = active_q;
    steep_d     = steep_q;
    minor_neg_d = minor_neg_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    err_d       = err_q;
    inc_s_d     = inc_s_q;
    inc_d_d     = inc_d_q;
    left_d      = left_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (proc_fire && op_q == OP_LOAD) begin
      active_d    = setup.major_len != '0;
      steep_d     = setup.steep;
      minor_neg_d = setup.minor_neg;
      cur_x_d     = setup.start_x;
      cur_y_d     = setup.start_y;
      err_d       = setup.err_init;
      inc_s_d     = setup.inc_straight;
      inc_d_d     = setup.inc_diagonal;
      left_d      = setup.major_len;
    end else if (step_fire) begin
      out_valid_d = 1'b1;
      if (err_q[ErrBits-1]) begin
        err_d = err_q + inc_s_q;
      end else begin
        err_d = err_q + inc_d_q;
        if (steep_q) begin
          cur_x_d = minor_next;
        end else begin
          cur_y_d = minor_next;
        end
      end
      if (steep_q) begin
        cur_y_d = coord_t'(cur_y_q + 1'b1);
      end else begin
        cur_x_d = coord_t'(cur_x_q + 1'b1);
      end
      left_d   = coord_t'(left_q - 1'b1);
      active_d = left_q != coord_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      steep_q     <= 1'b0;
      minor_neg_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      inc_s_q     <= '0;
      inc_d_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      steep_q     <= steep_d;
      minor_neg_q <= minor_neg_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      err_q       <= err_d;
      inc_s_q     <= inc_s_d;
      inc_d_q     <= inc_d_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      pix_x_q <= cur_x_q;
      pix_y_q <= cur_y_q;
      last_q  <= left_q == coord_t'(1);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign last_pixel_o = last_q;

`ifndef SYNTHESIS
  a_active_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> left_q != '0)
    else $error("active line with no pixels left");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && left_q == coord_t'(1)) |=> !active_q)
    else $error("line still active after its last pixel");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a held item and a pending result");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> (out_valid_q && last_q == $past(left_q == coord_t'(1))))
    else $error("step did not produce a matching result");
`endif

endmodule : bresenham_line_stepper
